// File: sv/i2csm_pkg.sv
package i2csm_pkg;

   // Default store depth
   localparam int I2CSM_BUF_DEPTH = 256;

   // Event codes
   localparam logic [2:0] MODE_ADDR_MATCH = 3'd0;
   localparam logic [2:0] MODE_RX_BYTE    = 3'd1;
   localparam logic [2:0] MODE_TX_REQ     = 3'd2;
   localparam logic [2:0] MODE_STOP       = 3'd3;
   localparam logic [2:0] MODE_ACK_FAIL   = 3'd4;
   localparam logic [2:0] MODE_BUS_ERROR  = 3'd5;
   localparam logic [2:0] MODE_HOST_LOAD  = 3'd6;
   localparam logic [2:0] MODE_HOST_READ  = 3'd7;

   // Phase codes
   localparam logic [1:0] PH_WAIT = 2'd0;
   localparam logic [1:0] PH_RECV = 2'd1;
   localparam logic [1:0] PH_SEND = 2'd2;

   // Register indexes (word address bit 2)
   localparam logic REG_RX_WRAP_LIMIT = 1'b0;
   localparam logic REG_TX_WRAP_LIMIT = 1'b1;

   typedef struct packed {
      logic [2:0] mode;
      logic       master_reads;
      logic [7:0] data_byte;
      logic [7:0] host_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic [7:0]  read_byte;
      logic [7:0]  frame_length;
      logic [15:0] frame_total;
      logic [1:0]  phase_now;
   } rsp_type;

   // Step an index, wrapping to zero once it passes the limit
   function automatic logic [7:0] advance(input logic [7:0] idx, input logic [7:0] limit);
      logic [8:0] nxt;
      nxt = {1'b0, idx} + 9'd1;
      if (nxt > {1'b0, limit}) begin
         return 8'd0;
      end
      return nxt[7:0];
   endfunction

endpackage

// File: sv/i2csm_chan_if.sv
interface i2csm_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: sv/i2csm_ram.sv
module i2csm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/i2c_slave_mailbox_unit.sv
// Slave-side I2C byte mailbox. Each request carries one bus or host event and
// yields exactly one response with the transmit byte, the host read byte, the
// last frame length, the frame count and the phase after the event. Requests
// are handled one at a time: each passes from accept through store access and
// the registered store read into the response register, and no new request is
// taken until then; a response left waiting in the output register holds the
// next request in its read cycle. Receive and transmit bytes live in two
// single-port-write, registered-read memories of BUF_DEPTH entries that are
// not cleared by reset; a host read of a receive entry that was never written
// returns an undefined byte. The user must write wrap limits through the APB
// port only while the block is idle; the block itself does not enforce this.
module i2c_slave_mailbox_unit
   import i2csm_pkg::*;
#(
   parameter int BUF_DEPTH = I2CSM_BUF_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   i2csm_chan_if.sink   req_bus,
   i2csm_chan_if.source rsp_bus,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int AW = $clog2(BUF_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [1:0]  state_ff, state_in;
   req_type     req_ff;
   logic [7:0]  rx_limit_ff, tx_limit_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  rx_idx_ff, rx_idx_in;
   logic [7:0]  tx_idx_ff, tx_idx_in;
   logic [7:0]  last_len_ff, last_len_in;
   logic [15:0] stop_cnt_ff, stop_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic          rx_we, rx_re, tx_we, tx_re;
   logic [AW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
   logic [7:0]    rx_wdata, tx_wdata, rx_rdata, tx_rdata;
   logic [AW-1:0] slot_tbl [256];
   logic          cfg_write, req_fire, rsp_free;

   // Map an 8-bit index onto a store entry (index modulo depth)
   for (genvar g = 0; g < 256; g++) begin : g_slot
      assign slot_tbl[g] = AW'(g % BUF_DEPTH);
   end

   // Configuration port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_TX_WRAP_LIMIT) ? {24'd0, tx_limit_ff}
                                                            : {24'd0, rx_limit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_limit_ff <= 8'hFF;
         tx_limit_ff <= 8'hFF;
      end else if (cfg_write) begin
         if (csr_paddr[2] == REG_RX_WRAP_LIMIT) begin
            rx_limit_ff <= csr_pwdata[7:0];
         end else begin
            tx_limit_ff <= csr_pwdata[7:0];
         end
      end
   end

   // Handshakes
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_ff;

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_bus.data;
      end
   end

   // Store access and state update in the execute cycle
   always_comb begin
      phase_in    = phase_ff;
      rx_idx_in   = rx_idx_ff;
      tx_idx_in   = tx_idx_ff;
      last_len_in = last_len_ff;
      stop_cnt_in = stop_cnt_ff;
      rx_we       = 1'b0;
      rx_waddr    = slot_tbl[rx_idx_ff];
      rx_wdata    = req_ff.data_byte;
      rx_re       = 1'b0;
      rx_raddr    = slot_tbl[req_ff.host_index];
      tx_we       = 1'b0;
      tx_waddr    = slot_tbl[req_ff.host_index];
      tx_wdata    = req_ff.data_byte;
      tx_re       = 1'b0;
      tx_raddr    = slot_tbl[tx_idx_ff];
      if (state_ff == ST_EXEC) begin
         unique case (req_ff.mode)
            MODE_ADDR_MATCH: begin
               if (req_ff.master_reads) begin
                  phase_in  = PH_SEND;
                  tx_idx_in = 8'd0;
               end else begin
                  phase_in  = PH_RECV;
                  rx_idx_in = 8'd0;
               end
            end
            MODE_RX_BYTE: begin
               rx_we = 1'b1;
               if (phase_ff == PH_RECV) begin
                  rx_idx_in = advance(rx_idx_ff, rx_limit_ff);
               end else begin
                  phase_in  = PH_WAIT;
                  rx_idx_in = 8'd0;
                  rx_waddr  = '0;
               end
            end
            MODE_TX_REQ: begin
               tx_re = 1'b1;
               if (phase_ff == PH_SEND) begin
                  tx_idx_in = advance(tx_idx_ff, tx_limit_ff);
               end else begin
                  phase_in  = PH_WAIT;
                  tx_idx_in = 8'd0;
                  tx_raddr  = '0;
               end
            end
            MODE_STOP: begin
               last_len_in = rx_idx_ff;
               stop_cnt_in = stop_cnt_ff + 16'd1;
               phase_in    = PH_WAIT;
            end
            MODE_ACK_FAIL: begin
               phase_in = PH_WAIT;
            end
            MODE_BUS_ERROR: begin
               phase_in  = PH_WAIT;
               rx_idx_in = 8'd0;
               tx_idx_in = 8'd0;
            end
            MODE_HOST_LOAD: begin
               tx_we = 1'b1;
            end
            MODE_HOST_READ: begin
               rx_re = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Response formed once the store read data is back
   always_comb begin
      rsp_in              = rsp_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_bus.ready;
      rsp_in.tx_byte      = (req_ff.mode == MODE_TX_REQ) ? tx_rdata : 8'd0;
      rsp_in.tx_valid     = (req_ff.mode == MODE_TX_REQ);
      rsp_in.read_byte    = (req_ff.mode == MODE_HOST_READ) ? rx_rdata : 8'd0;
      rsp_in.frame_length = last_len_ff;
      rsp_in.frame_total  = stop_cnt_ff;
      rsp_in.phase_now    = phase_ff;
      if (state_ff == ST_READ && rsp_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and mailbox state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_WAIT;
         rx_idx_ff    <= 8'd0;
         tx_idx_ff    <= 8'd0;
         last_len_ff  <= 8'd0;
         stop_cnt_ff  <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rx_idx_ff    <= rx_idx_in;
         tx_idx_ff    <= tx_idx_in;
         last_len_ff  <= last_len_in;
         stop_cnt_ff  <= stop_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ && rsp_free) begin
         rsp_ff <= rsp_in;
      end
   end

   // Receive and transmit byte stores
   i2csm_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_rx_store (
      .clock (clock),
      .we    (rx_we),
      .waddr (rx_waddr),
      .wdata (rx_wdata),
      .re    (rx_re),
      .raddr (rx_raddr),
      .rdata (rx_rdata)
   );

   i2csm_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_tx_store (
      .clock (clock),
      .we    (tx_we),
      .waddr (tx_waddr),
      .wdata (tx_wdata),
      .re    (tx_re),
      .raddr (tx_raddr),
      .rdata (tx_rdata)
   );

endmodule

// File: tb/sv/i2csm_mailbox_checker.sv
module i2csm_mailbox_checker
   import i2csm_pkg::*;
#(
   parameter int BUF_DEPTH = I2CSM_BUF_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 30;
   localparam int AW = $clog2(BUF_DEPTH);

   // Shadow of the mailbox state
   logic [7:0]  rx_limit;
   logic [7:0]  tx_limit;
   logic [1:0]  bus_phase;
   logic [7:0]  rx_idx;
   logic [7:0]  tx_idx;
   logic [7:0]  length_seen;
   logic [15:0] stops_seen;
   logic [7:0]  rx_mem [BUF_DEPTH];
   logic [7:0]  tx_mem [BUF_DEPTH];

   rsp_type awaited_rsp [$];
   rsp_type want;
   rsp_type next_rsp;

   function automatic logic [7:0] next_index(input logic [7:0] idx, input logic [7:0] lim);
      return (idx >= lim) ? 8'd0 : idx + 8'd1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int wanted);
      if (fail_count < PRINT_CAP) begin
         $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
      end
      fail_count++;
   endtask

   // Advance the shadow state by one request and build its response
   task automatic apply_bus_event(input req_type ev, output rsp_type out);
      out = '0;
      case (ev.mode)
         MODE_ADDR_MATCH: begin
            if (ev.master_reads) begin
               bus_phase = PH_SEND;
               tx_idx = 8'd0;
            end else begin
               bus_phase = PH_RECV;
               rx_idx = 8'd0;
            end
         end
         MODE_RX_BYTE: begin
            if (bus_phase == PH_RECV) begin
               rx_mem[AW'(int'(rx_idx) % BUF_DEPTH)] = ev.data_byte;
               rx_idx = next_index(rx_idx, rx_limit);
            end else begin
               // stray byte restarts at entry zero
               bus_phase = PH_WAIT;
               rx_idx = 8'd0;
               rx_mem[0] = ev.data_byte;
            end
         end
         MODE_TX_REQ: begin
            out.tx_valid = 1'b1;
            if (bus_phase == PH_SEND) begin
               out.tx_byte = tx_mem[AW'(int'(tx_idx) % BUF_DEPTH)];
               tx_idx = next_index(tx_idx, tx_limit);
            end else begin
               bus_phase = PH_WAIT;
               tx_idx = 8'd0;
               out.tx_byte = tx_mem[0];
            end
         end
         MODE_STOP: begin
            length_seen = rx_idx;
            stops_seen = stops_seen + 16'd1;
            bus_phase = PH_WAIT;
         end
         MODE_ACK_FAIL: begin
            bus_phase = PH_WAIT;
         end
         MODE_BUS_ERROR: begin
            bus_phase = PH_WAIT;
            rx_idx = 8'd0;
            tx_idx = 8'd0;
         end
         MODE_HOST_LOAD: begin
            tx_mem[AW'(int'(ev.host_index) % BUF_DEPTH)] = ev.data_byte;
         end
         default: begin
            out.read_byte = rx_mem[AW'(int'(ev.host_index) % BUF_DEPTH)];
         end
      endcase
      out.frame_length = length_seen;
      out.frame_total = stops_seen;
      out.phase_now = bus_phase;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rx_limit = 8'd255;
         tx_limit = 8'd255;
         bus_phase = PH_WAIT;
         rx_idx = 8'd0;
         tx_idx = 8'd0;
         length_seen = 8'd0;
         stops_seen = 16'd0;
         fail_count = 0;
         awaited_rsp.delete();
      end else begin
         // track wrap limit writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_RX_WRAP_LIMIT) begin
               rx_limit = csr_pwdata[7:0];
            end else begin
               tx_limit = csr_pwdata[7:0];
            end
         end

         // compare the response against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("responses outstanding", 1, 0);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.tx_byte !== want.tx_byte) begin
                  report_mismatch("tx_byte", int'(rsp_data.tx_byte), int'(want.tx_byte));
               end
               if (rsp_data.tx_valid !== want.tx_valid) begin
                  report_mismatch("tx_valid", int'(rsp_data.tx_valid), int'(want.tx_valid));
               end
               if (rsp_data.read_byte !== want.read_byte) begin
                  report_mismatch("read_byte", int'(rsp_data.read_byte),
                                  int'(want.read_byte));
               end
               if (rsp_data.frame_length !== want.frame_length) begin
                  report_mismatch("frame_length", int'(rsp_data.frame_length),
                                  int'(want.frame_length));
               end
               if (rsp_data.frame_total !== want.frame_total) begin
                  report_mismatch("frame_total", int'(rsp_data.frame_total),
                                  int'(want.frame_total));
               end
               if (rsp_data.phase_now !== want.phase_now) begin
                  report_mismatch("phase_now", int'(rsp_data.phase_now),
                                  int'(want.phase_now));
               end
            end
         end

         // predict the response for each accepted request
         if (req_valid && req_ready) begin
            apply_bus_event(req_data, next_rsp);
            awaited_rsp.push_back(next_rsp);
         end
      end
      pending = awaited_rsp.size();
   end

endmodule

// File: tb/sv/tb_i2c_slave_mailbox_unit.sv
module tb_i2c_slave_mailbox_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import i2csm_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int RESET_CYCLES = 7;
   localparam int LONG_HOLD = 80;
   localparam int HOLD_AFTER = 700;
   localparam int SEGMENT_ITEMS = 160;
   localparam int TAIL_CYCLES = 10;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending;
   int sent_count;
   int send_idle_pct;
   int recv_idle_pct;
   int rx_lim_now;
   int tx_lim_now;
   int cycle_count;
   int hold_left;
   bit held_once;

   i2csm_chan_if #(.payload_type(req_type)) req_if ();
   i2csm_chan_if #(.payload_type(rsp_type)) rsp_if ();

   i2c_slave_mailbox_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   i2csm_mailbox_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_data    (req_if.data),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_data    (rsp_if.data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic req_type make_req(input logic [2:0] mode, input logic dir,
                                        input logic [7:0] data, input logic [7:0] idx);
      req_type r;
      r.mode = mode;
      r.master_reads = dir;
      r.data_byte = data;
      r.host_index = idx;
      return r;
   endfunction

   function automatic req_type rand_req(input logic [2:0] mode);
      return make_req(mode, 1'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   // Mostly short frames; now and then one long enough to wrap
   function automatic int frame_bytes(input int lim);
      if (lim < 16) begin
         return $urandom_range(lim + 2, 0);
      end
      if ($urandom_range(19, 0) == 0) begin
         return $urandom_range(lim + 2, 0);
      end
      return $urandom_range(12, 0);
   endfunction

   function automatic logic [2:0] frame_end();
      int pick;
      pick = $urandom_range(9, 0);
      if (pick == 0) begin
         return MODE_ACK_FAIL;
      end
      if (pick == 1) begin
         return MODE_BUS_ERROR;
      end
      return MODE_STOP;
   endfunction

   // Offer one request, with random idle cycles first, and hold until taken
   task automatic offer_request(input req_type r);
      logic taken;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= r;
      do begin
         @(negedge clock);
         taken = req_if.ready;
         @(posedge clock);
      end while (!taken);
      sent_count++;
   endtask

   // Stop offering and wait until every response has come back
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending != 0);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic reg_sel, input logic [7:0] value);
      logic done;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         done = csr_pready;
         @(posedge clock);
      end while (!done);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_wrap_limits(input int rx_lim, input int tx_lim);
      drain_responses();
      write_csr(REG_RX_WRAP_LIMIT, 8'(rx_lim));
      write_csr(REG_TX_WRAP_LIMIT, 8'(tx_lim));
      rx_lim_now = rx_lim;
      tx_lim_now = tx_lim;
   endtask

   // Load every transmit entry and fill every receive entry with one full frame
   task automatic fill_stores();
      for (int i = 0; i < I2CSM_BUF_DEPTH; i++) begin
         offer_request(make_req(MODE_HOST_LOAD, 1'($urandom), 8'($urandom), 8'(i)));
      end
      offer_request(make_req(MODE_ADDR_MATCH, 1'b0, 8'($urandom), 8'($urandom)));
      repeat (I2CSM_BUF_DEPTH) offer_request(rand_req(MODE_RX_BYTE));
      offer_request(rand_req(MODE_STOP));
   endtask

   task automatic directed_events();
      offer_request(make_req(MODE_HOST_LOAD, 1'b1, 8'hFF, 8'hFF));
      offer_request(make_req(MODE_HOST_LOAD, 1'b0, 8'h00, 8'h00));
      // transmit request and byte while waiting for an address
      offer_request(make_req(MODE_TX_REQ, 1'b0, 8'h00, 8'h00));
      offer_request(make_req(MODE_RX_BYTE, 1'b1, 8'hFF, 8'hFF));
      // read transfer, then a stray byte while sending
      offer_request(make_req(MODE_ADDR_MATCH, 1'b1, 8'hFF, 8'h00));
      offer_request(make_req(MODE_TX_REQ, 1'b0, 8'h00, 8'hFF));
      offer_request(make_req(MODE_TX_REQ, 1'b1, 8'hFF, 8'h00));
      offer_request(make_req(MODE_RX_BYTE, 1'b0, 8'h00, 8'h00));
      // write transfer, then a stray transmit request while receiving
      offer_request(make_req(MODE_ADDR_MATCH, 1'b0, 8'h00, 8'hFF));
      offer_request(make_req(MODE_RX_BYTE, 1'b0, 8'hA5, 8'h5A));
      offer_request(make_req(MODE_RX_BYTE, 1'b1, 8'h5A, 8'hA5));
      offer_request(make_req(MODE_TX_REQ, 1'b0, 8'h00, 8'h00));
      offer_request(make_req(MODE_STOP, 1'b1, 8'hFF, 8'hFF));
      // ack failure mid-frame, then a byte after it
      offer_request(make_req(MODE_ADDR_MATCH, 1'b0, 8'h00, 8'h00));
      offer_request(make_req(MODE_RX_BYTE, 1'b0, 8'h3C, 8'h00));
      offer_request(make_req(MODE_ACK_FAIL, 1'b0, 8'h00, 8'h00));
      offer_request(make_req(MODE_RX_BYTE, 1'b0, 8'hC3, 8'h00));
      offer_request(make_req(MODE_STOP, 1'b0, 8'h00, 8'h00));
      // bus error mid-read clears both indices
      offer_request(make_req(MODE_ADDR_MATCH, 1'b1, 8'h00, 8'h00));
      offer_request(make_req(MODE_TX_REQ, 1'b0, 8'h00, 8'h00));
      offer_request(make_req(MODE_BUS_ERROR, 1'b1, 8'hFF, 8'hFF));
      offer_request(make_req(MODE_TX_REQ, 1'b0, 8'h00, 8'h00));
      offer_request(make_req(MODE_HOST_READ, 1'b0, 8'h00, 8'h00));
      offer_request(make_req(MODE_HOST_READ, 1'b1, 8'hFF, 8'hFF));
      offer_request(make_req(MODE_ACK_FAIL, 1'b1, 8'hFF, 8'hFF));
      offer_request(make_req(MODE_BUS_ERROR, 1'b0, 8'h00, 8'h00));
   endtask

   // Mostly well-formed transfers with random content, plus host traffic and noise
   task automatic random_traffic(input int items);
      int start;
      int kind;
      int len;
      start = sent_count;
      while (sent_count - start < items) begin
         kind = $urandom_range(99, 0);
         if (kind < 35) begin
            offer_request(make_req(MODE_ADDR_MATCH, 1'b0, 8'($urandom), 8'($urandom)));
            len = frame_bytes(rx_lim_now);
            repeat (len) offer_request(rand_req(MODE_RX_BYTE));
            offer_request(rand_req(frame_end()));
         end else if (kind < 65) begin
            offer_request(make_req(MODE_ADDR_MATCH, 1'b1, 8'($urandom), 8'($urandom)));
            len = frame_bytes(tx_lim_now);
            repeat (len) offer_request(rand_req(MODE_TX_REQ));
            offer_request(rand_req(frame_end()));
         end else if (kind < 85) begin
            repeat ($urandom_range(4, 1)) begin
               offer_request(rand_req(($urandom_range(1, 0) == 1) ? MODE_HOST_LOAD
                                                                   : MODE_HOST_READ));
            end
         end else begin
            repeat ($urandom_range(3, 1)) offer_request(rand_req(3'($urandom_range(7, 0))));
         end
      end
   endtask

   // Response side: random stalls plus one long hold-off while requests keep coming
   initial begin
      rsp_if.ready = 1'b0;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_once && sent_count >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sent_count = 0;
      send_idle_pct = 18;
      recv_idle_pct = 51;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      program_wrap_limits(255, 255);
      fill_stores();
      directed_events();

      program_wrap_limits(0, 0);
      random_traffic(SEGMENT_ITEMS);
      program_wrap_limits($urandom_range(6, 1), $urandom_range(6, 1));
      random_traffic(SEGMENT_ITEMS);

      send_idle_pct = 51;
      recv_idle_pct = 18;
      program_wrap_limits(255, 255);
      random_traffic(SEGMENT_ITEMS);
      program_wrap_limits($urandom_range(255, 0), $urandom_range(255, 0));
      random_traffic(SEGMENT_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_wrap_limits($urandom_range(10, 1), $urandom_range(10, 1));
      random_traffic(SEGMENT_ITEMS);

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

endmodule
